[sv/u8u16_pkg.sv]
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the transaction structs, the decoder-to-queue struct and code point limits.
// No dependencies.
`default_nettype none

package u8u16_pkg;

  // Input transaction: one UTF-8 byte and its end-of-string mark
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  // Output transaction: one UTF-16 code unit or an error mark
  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_error;
    logic        last_of_string;
  } out_item_t;

  // Result queue geometry (depth must be a power of two, at least two)
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Results handed from the decoder to the queue for one taken byte
  typedef struct packed {
    logic [1:0] num;
    out_item_t  r0;
    out_item_t  r1;
  } dec_res_t;

  // Sequence lengths
  localparam logic [2:0] SEQ_IDLE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // Code point limits
  localparam logic [20:0] CP_MIN_LEN2  = 21'h000080;
  localparam logic [20:0] CP_MIN_LEN3  = 21'h000800;
  localparam logic [20:0] CP_MIN_LEN4  = 21'h010000;
  localparam logic [20:0] CP_SUR_FIRST = 21'h00D800;
  localparam logic [20:0] CP_SUR_LAST  = 21'h00DFFF;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;

  // Surrogate unit bases
  localparam logic [15:0] SUR_HI_BASE = 16'hD800;
  localparam logic [15:0] SUR_LO_BASE = 16'hDC00;

endpackage

`default_nettype wire

[sv/u8u16_decode.sv]
// Sequence decoder: holds the partial code point state and checks each byte.
// Produces zero, one or two results per taken byte. Depends on u8u16_pkg.
`default_nettype none

module u8u16_decode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                take_i,
  input  wire u8u16_pkg::in_item_t item_i,
  output u8u16_pkg::dec_res_t      res_o
);
  import u8u16_pkg::*;

  logic [20:0] point_q, point_d;
  logic [1:0]  pend_q, pend_d;
  logic [2:0]  len_q, len_d;
  logic        disc_q, disc_d;

  logic [7:0]  b;
  logic        eos;
  logic [20:0] cp;
  logic [20:0] least;
  logic [1:0]  pend_dec;
  logic        cont_ok;
  logic        cp_bad;
  logic [20:0] cp_off;
  logic        fail;
  dec_res_t    res;

  assign b        = item_i.in_byte;
  assign eos      = item_i.end_of_string;
  assign cp       = {point_q[14:0], b[5:0]};
  assign pend_dec = pend_q - 2'd1;
  assign cont_ok  = (b[7:6] == 2'b10);
  assign cp_off   = cp - CP_MIN_LEN4;

  // Pick the smallest legal value for the sequence length
  always_comb begin
    case (len_q)
      SEQ_LEN2: least = CP_MIN_LEN2;
      SEQ_LEN3: least = CP_MIN_LEN3;
      default:  least = CP_MIN_LEN4;
    endcase
  end

  assign cp_bad = (cp < least) || (cp inside {[CP_SUR_FIRST:CP_SUR_LAST]}) || (cp > CP_MAX);

  // Decode one byte against the current sequence state
  always_comb begin
    point_d = point_q;
    pend_d  = pend_q;
    len_d   = len_q;
    disc_d  = disc_q;
    fail    = 1'b0;
    res     = '0;
    if (disc_q) begin
      // Swallow until the end of the string
      if (eos) begin
        disc_d  = 1'b0;
        point_d = '0;
        pend_d  = '0;
        len_d   = SEQ_IDLE;
      end
    end else if (pend_q == 2'd0) begin
      if (!b[7]) begin
        point_d = '0;
        pend_d  = '0;
        len_d   = SEQ_IDLE;
        res.num = 2'd1;
        res.r0  = '{code_unit: {8'h00, b}, is_error: 1'b0, last_of_string: eos};
      end else if (b[7:5] == 3'b110) begin
        point_d = {16'h0, b[4:0]};
        len_d   = SEQ_LEN2;
        pend_d  = 2'd1;
        fail    = eos;
      end else if (b[7:4] == 4'b1110) begin
        point_d = {17'h0, b[3:0]};
        len_d   = SEQ_LEN3;
        pend_d  = 2'd2;
        fail    = eos;
      end else if (b[7:3] == 5'b11110) begin
        point_d = {18'h0, b[2:0]};
        len_d   = SEQ_LEN4;
        pend_d  = 2'd3;
        fail    = eos;
      end else begin
        fail = 1'b1;
      end
    end else if (!cont_ok) begin
      fail = 1'b1;
    end else if (pend_dec != 2'd0) begin
      // Middle byte of a longer sequence
      point_d = cp;
      pend_d  = pend_dec;
      fail    = eos;
    end else if (cp_bad) begin
      fail = 1'b1;
    end else begin
      // Sequence complete: emit one unit or a surrogate pair
      point_d = '0;
      pend_d  = '0;
      len_d   = SEQ_IDLE;
      if (cp <= CP_BMP_MAX) begin
        res.num = 2'd1;
        res.r0  = '{code_unit: cp[15:0], is_error: 1'b0, last_of_string: eos};
      end else begin
        res.num = 2'd2;
        res.r0  = '{code_unit: SUR_HI_BASE + {6'h0, cp_off[19:10]},
                    is_error: 1'b0, last_of_string: 1'b0};
        res.r1  = '{code_unit: SUR_LO_BASE + {6'h0, cp_off[9:0]},
                    is_error: 1'b0, last_of_string: eos};
      end
    end
    // Report the first error and drop the sequence
    if (fail) begin
      point_d = '0;
      pend_d  = '0;
      len_d   = SEQ_IDLE;
      disc_d  = ~eos;
      res     = '0;
      res.num = 2'd1;
      res.r0  = '{code_unit: 16'h0000, is_error: 1'b1, last_of_string: 1'b1};
    end
  end

  // Hand results out only for a taken byte
  always_comb begin
    res_o = res;
    if (!take_i) begin
      res_o.num = 2'd0;
    end
  end

  // Advance sequence state on each taken byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q <= '0;
      pend_q  <= '0;
      len_q   <= SEQ_IDLE;
      disc_q  <= 1'b0;
    end else if (take_i) begin
      point_q <= point_d;
      pend_q  <= pend_d;
      len_q   <= len_d;
      disc_q  <= disc_d;
    end
  end

  // An error result is the only and final result of its byte
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.num != 2'd0 && res_o.r0.is_error) |-> (res_o.num == 2'd1 && res_o.r0.last_of_string))
    else $error("error result not alone or not last");

  // A pair always carries a high then a low surrogate
  a_pair_sur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.num == 2'd2) |->
      (res_o.r0.code_unit[15:10] == 6'b110110 && res_o.r1.code_unit[15:10] == 6'b110111))
    else $error("surrogate pair malformed");

  // No sequence is held while swallowing
  a_disc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (pend_q == 2'd0 && len_q == SEQ_IDLE))
    else $error("sequence pending while discarding");

  // Nothing comes out while swallowing
  a_disc_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (res_o.num == 2'd0))
    else $error("result while discarding");

endmodule

`default_nettype wire

[sv/u8u16_res_queue.sv]
// Result queue: small flop-based buffer that takes up to two results per cycle.
// Drives the output channel from registers. Depends on u8u16_pkg.
`default_nettype none

module u8u16_res_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire u8u16_pkg::dec_res_t  push_i,
  output logic                      space_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output u8u16_pkg::out_item_t      out_item_o
);
  import u8u16_pkg::*;

  out_item_t               mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]    wr_q, wr_d;
  logic [RES_PTR_W-1:0]    rd_q, rd_d;
  logic [RES_CNT_W-1:0]    cnt_q, cnt_d;
  logic [RES_PTR_W-1:0]    wr_nxt;
  logic                    pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign space_o     = (cnt_q <= RES_CNT_W'(RES_DEPTH - 2));
  assign wr_nxt      = wr_q + RES_PTR_W'(1);

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q + RES_PTR_W'(push_i.num);
    rd_d  = rd_q + RES_PTR_W'(pop);
    cnt_d = cnt_q + RES_CNT_W'(push_i.num) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store incoming results
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

  // Pushes only arrive with room for a pair
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> (cnt_q <= RES_CNT_W'(RES_DEPTH - 2)))
    else $error("result queue overflow");

  // Fill count never exceeds the depth
  a_cnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_CNT_W'(RES_DEPTH))
    else $error("result count out of range");

  // Pointer distance matches the fill count
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[RES_PTR_W-1:0])
    else $error("pointers disagree with count");

endmodule

`default_nettype wire

[sv/utf8_to_utf16_transcoder.sv]
// Strict UTF-8 to UTF-16 transcoder, one byte per transaction.
// Path: an accepted byte waits in the input register until the queue has room for a
// pair, is decoded, and its results are offered from the result queue's registers.
// Throughput: one byte per cycle while the consumer keeps up; a four-byte sequence
// yields a surrogate pair through a four-entry result queue, and input stalls while
// the queue holds more than two results.
// Reset (rst_ni low, asynchronous) clears the sequence state and empties the queue.
// Depends on u8u16_pkg, u8u16_decode and u8u16_res_queue.
`default_nettype none

module utf8_to_utf16_transcoder (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire u8u16_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output u8u16_pkg::out_item_t      out_item_o
);
  import u8u16_pkg::*;

  logic     in_vld_q;
  in_item_t in_item_q;
  logic     space;
  logic     drain;
  dec_res_t dec_res;

  // Drain the input register once the queue has room for a pair
  assign drain      = in_vld_q & space;
  assign in_ready_o = ~in_vld_q | drain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Hold the byte until it is decoded
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  u8u16_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (drain),
    .item_i (in_item_q),
    .res_o  (dec_res)
  );

  u8u16_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (dec_res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // A held byte is decoded whenever the queue has room
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && space) |-> (dec_res.num != 2'd0 || !in_ready_o == 1'b0))
    else $error("held byte not drained");

  // Results only appear for a decoded byte
  a_push_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_res.num != 2'd0) |-> drain)
    else $error("result without a byte");

  // A pending byte with no room blocks new input
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !space) |-> !in_ready_o)
    else $error("input taken while stalled");

endmodule

`default_nettype wire

[dv/utf8_to_utf16_transcoder_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for utf8_to_utf16_transcoder: strict UTF-8 strings in, UTF-16 units out.
// Depends on u8u16_pkg and the transcoder RTL; a scoreboard class predicts every code unit.

module utf8_to_utf16_transcoder_tb;
  import u8u16_pkg::*;

  // Scoreboard: decodes accepted bytes and holds the code units still owed
  class utf16_scoreboard;
    logic [20:0] partial_point;
    logic [1:0]  bytes_left;
    logic [2:0]  seq_len;
    bit          discarding;
    out_item_t   owed_units[$];
    int          fail_count;

    function new();
      partial_point = '0;
      bytes_left    = '0;
      seq_len       = SEQ_IDLE;
      discarding    = 1'b0;
      fail_count    = 0;
    endfunction

    function int pending();
      return owed_units.size();
    endfunction

    function void clear_sequence();
      partial_point = '0;
      bytes_left    = '0;
      seq_len       = SEQ_IDLE;
    endfunction

    function void add_unit(logic [15:0] unit, bit err, bit last);
      out_item_t e;
      e.code_unit      = unit;
      e.is_error       = err;
      e.last_of_string = last;
      owed_units.insert(owed_units.size(), e);
    endfunction

    // Reject the string: one error unit, then swallow until the end mark
    function void reject(bit eos);
      clear_sequence();
      discarding = !eos;
      add_unit(16'd0, 1'b1, 1'b1);
    endfunction

    // Note one accepted byte; return 0 when the byte is swallowed
    function bit note_byte(in_item_t it);
      logic [7:0]  b;
      bit          eos;
      logic [20:0] cp;
      logic [20:0] least;
      logic [20:0] off;
      b   = it.in_byte;
      eos = it.end_of_string;
      if (discarding) begin
        if (eos) begin
          discarding = 1'b0;
          clear_sequence();
        end
        return 1'b0;
      end
      // Lead byte
      if (bytes_left == 2'd0) begin
        if (!b[7]) begin
          clear_sequence();
          add_unit({8'd0, b}, 1'b0, eos);
          return 1'b1;
        end
        if (b[7:5] == 3'b110) begin
          partial_point = {16'd0, b[4:0]};
          seq_len       = SEQ_LEN2;
        end else if (b[7:4] == 4'b1110) begin
          partial_point = {17'd0, b[3:0]};
          seq_len       = SEQ_LEN3;
        end else if (b[7:3] == 5'b11110) begin
          partial_point = {18'd0, b[2:0]};
          seq_len       = SEQ_LEN4;
        end else begin
          reject(eos);
          return 1'b1;
        end
        if (eos) begin
          reject(eos);
          return 1'b1;
        end
        bytes_left = 2'(seq_len - 3'd1);
        return 1'b1;
      end
      // Continuation byte
      if (b[7:6] != 2'b10) begin
        reject(eos);
        return 1'b1;
      end
      partial_point = {partial_point[14:0], b[5:0]};
      bytes_left    = bytes_left - 2'd1;
      if (bytes_left != 2'd0) begin
        if (eos) reject(eos);
        return 1'b1;
      end
      // Sequence complete: range checks
      cp = partial_point;
      if (seq_len == SEQ_LEN2) least = CP_MIN_LEN2;
      else if (seq_len == SEQ_LEN3) least = CP_MIN_LEN3;
      else least = CP_MIN_LEN4;
      if (cp < least || (cp >= CP_SUR_FIRST && cp <= CP_SUR_LAST) || cp > CP_MAX) begin
        reject(eos);
        return 1'b1;
      end
      clear_sequence();
      if (cp <= CP_BMP_MAX) begin
        add_unit(cp[15:0], 1'b0, eos);
      end else begin
        off = cp - CP_MIN_LEN4;
        add_unit(SUR_HI_BASE + {6'd0, off[19:10]}, 1'b0, 1'b0);
        add_unit(SUR_LO_BASE + {6'd0, off[9:0]}, 1'b0, eos);
      end
      return 1'b1;
    endfunction

    // Compare one delivered unit with the oldest owed one
    function void check_unit(out_item_t got);
      out_item_t exp_unit;
      if (owed_units.size() == 0) begin
        $error("unexpected transaction: code_unit %h is_error %b last_of_string %b",
               got.code_unit, got.is_error, got.last_of_string);
        fail_count++;
        return;
      end
      exp_unit = owed_units.pop_front();
      if (got.code_unit !== exp_unit.code_unit) begin
        $error("code_unit: expected %h, actual %h", exp_unit.code_unit, got.code_unit);
        fail_count++;
      end
      if (got.is_error !== exp_unit.is_error) begin
        $error("is_error: expected %b, actual %b", exp_unit.is_error, got.is_error);
        fail_count++;
      end
      if (got.last_of_string !== exp_unit.last_of_string) begin
        $error("last_of_string: expected %b, actual %b",
               exp_unit.last_of_string, got.last_of_string);
        fail_count++;
      end
    endfunction
  endclass

  typedef enum {FLAW_LEAD, FLAW_CONT, FLAW_TRUNC, FLAW_OVERLONG, FLAW_SURROGATE, FLAW_HIGH}
    flaw_t;

  localparam int RANDOM_BYTES = 850;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  utf16_scoreboard sb = new();
  logic [7:0] string_bytes[$];
  int         decoded_bytes;
  bit         tx_idle;
  bit         rx_idle;
  int         rx_hold_left;

  utf8_to_utf16_transcoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Append one byte to the string under construction
  function automatic void add_byte(input logic [7:0] b);
    string_bytes.insert(string_bytes.size(), b);
  endfunction

  // Encode a code point in a given number of bytes, overlong forms included
  task automatic append_point(input logic [20:0] cp, input int len);
    case (len)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Pick a legal code point for a length, leaning on the range edges
  function automatic logic [20:0] pick_point(input int len);
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;
    int          r;
    case (len)
      1:       begin lo = 21'h0;       hi = 21'h7F;      end
      2:       begin lo = CP_MIN_LEN2; hi = 21'h7FF;     end
      3:       begin lo = CP_MIN_LEN3; hi = CP_BMP_MAX;  end
      default: begin lo = CP_MIN_LEN4; hi = CP_MAX;      end
    endcase
    r = int'($urandom_range(0, 9));
    if (r == 0) cp = lo;
    else if (r == 1) cp = hi;
    else cp = 21'($urandom_range(32'(hi), 32'(lo)));
    // steer away from the surrogate block
    if (cp >= CP_SUR_FIRST && cp <= CP_SUR_LAST) cp[13] = ~cp[13];
    return cp;
  endfunction

  // Append one malformed piece; truncation has to end the string
  task automatic append_flaw(output bit ends_string);
    flaw_t      flaw;
    int         len;
    logic [7:0] b;
    ends_string = 1'b0;
    flaw = flaw_t'($urandom_range(0, 5));
    len  = int'($urandom_range(2, 4));
    case (flaw)
      FLAW_LEAD: begin
        if ($urandom_range(0, 1) != 0) b = 8'($urandom_range(8'hBF, 8'h80));
        else b = 8'($urandom_range(8'hFF, 8'hF8));
        add_byte(b);
      end
      FLAW_CONT: begin
        append_point(pick_point(len), len);
        repeat ($urandom_range(1, len - 1)) void'(string_bytes.pop_back());
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        add_byte(b);
      end
      FLAW_TRUNC: begin
        append_point(pick_point(len), len);
        repeat ($urandom_range(1, len - 1)) void'(string_bytes.pop_back());
        ends_string = 1'b1;
      end
      FLAW_OVERLONG: begin
        if (len == 2) append_point(21'($urandom_range(0, 32'h7F)), len);
        else if (len == 3) append_point(21'($urandom_range(0, 32'h7FF)), len);
        else append_point(21'($urandom_range(0, 32'hFFFF)), len);
      end
      FLAW_SURROGATE:
        append_point(21'($urandom_range(32'(CP_SUR_LAST), 32'(CP_SUR_FIRST))), 3);
      default:
        append_point(21'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
    endcase
  endtask

  // Build a string: mostly well-formed, some with one flaw, a few pure noise
  task automatic build_random_string();
    int n;
    int mode;
    int flaw_at;
    bit stop;
    int len;
    n    = int'($urandom_range(1, 6));
    mode = int'($urandom_range(0, 99));
    if (mode >= 92) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    flaw_at = (mode < 70) ? -1 : int'($urandom_range(0, n - 1));
    for (int k = 0; k < n; k++) begin
      if (k == flaw_at) begin
        append_flaw(stop);
        if (stop) return;
      end else begin
        len = int'($urandom_range(1, 4));
        append_point(pick_point(len), len);
      end
    end
  endtask

  // Offer one byte; called at a falling edge and returns at one
  task automatic send_byte(input in_item_t it);
    while (tx_idle && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    void'(sb.note_byte(it));
    decoded_bytes++;
    @(negedge clk_i);
  endtask

  // Send the gathered bytes as one string, end mark on the last
  task automatic send_string();
    in_item_t it;
    for (int i = 0; i < string_bytes.size(); i++) begin
      it.in_byte       = string_bytes[i];
      it.end_of_string = (i == string_bytes.size() - 1);
      send_byte(it);
    end
    string_bytes.delete();
  endtask

  // Drop valid and hold until every owed unit has arrived
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  // Receiver: random stalls plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready_i <= !(rx_idle && $urandom_range(0, 99) < 25);
      end
    end
  end

  // Check every delivered transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_unit(out_item_o);
  end

  initial begin
    #200_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    bit held;
    bit paused;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;
    rx_hold_left  = 0;
    decoded_bytes = 0;
    held          = 1'b0;
    paused        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ASCII and two-byte edges
    append_point(21'h0, 1);
    append_point(CP_MIN_LEN2, 2);
    append_point(21'h7FF, 2);
    append_point(21'h7F, 1);
    send_string();
    // three-byte minimum, then the top code point as a pair carrying the end mark
    append_point(CP_MIN_LEN3, 3);
    append_point(CP_MAX, 4);
    send_string();
    // bad lead on the end-marked byte
    add_byte(8'hFF);
    send_string();
    // bad lead mid-string, rest swallowed
    add_byte(8'hF8);
    add_byte(8'h41);
    send_string();
    // bad continuation
    add_byte(8'hC2);
    add_byte(8'h00);
    send_string();
    // truncated four-byte sequence
    append_point(CP_MIN_LEN4, 4);
    void'(string_bytes.pop_back());
    void'(string_bytes.pop_back());
    send_string();
    // overlong, surrogate, above the top code point
    append_point(21'h3F, 2);
    send_string();
    append_point(CP_SUR_FIRST, 3);
    send_string();
    append_point(21'h110000, 4);
    send_string();

    // Random strings; the first stretch runs without idling
    decoded_bytes = 0;
    while (decoded_bytes < RANDOM_BYTES) begin
      tx_idle = (decoded_bytes >= 150);
      rx_idle = (decoded_bytes >= 150);
      if (!held && decoded_bytes >= 350) begin
        held         = 1'b1;
        rx_hold_left = 80;
      end
      if (!paused && decoded_bytes >= 600) begin
        paused = 1'b1;
        wait_for_drain();
      end
      build_random_string();
      send_string();
    end

    wait_for_drain();
    repeat (8) @(negedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/u8u16_pkg.sv
sv/u8u16_decode.sv
sv/u8u16_res_queue.sv
sv/utf8_to_utf16_transcoder.sv
dv/utf8_to_utf16_transcoder_tb.sv
